// ----- rtl/ssa_pkg.sv -----
// -----------------------------------------------------------------------------
// ssa_pkg
// Shared types and codes for the session slot allocator: request and result
// payloads, status and operation codes, controller command and status groups.
// -----------------------------------------------------------------------------
package ssa_pkg;

    localparam int WORD_W  = 32;   // slots per bitmap row
    localparam int WORD_LW = 5;    // log2 of WORD_W

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [9:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  granted_slot;
        logic [10:0] slots_in_use;
    } t_rsp;

    typedef struct packed {
        logic       clr_step;
        logic       accept;
        logic       rd_tgt;
        logic       alloc_mod;
        logic       free_mod;
        logic       sum_load;
        logic       invalidate;
        logic       pick;
        logic       rsp_load;
        logic [1:0] rsp_status;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pool_full;
        logic idx_ok;
        logic op_free;
        logic bit_set;
        logic inrow_hit;
        logic row_found;
    } t_sts;

endpackage

// ----- rtl/ssa_ram.sv -----
// -----------------------------------------------------------------------------
// ssa_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ssa_dp.sv -----
// -----------------------------------------------------------------------------
// ssa_dp
// Allocator datapath: row bitmap RAM, per-row full flags, next-free pointer,
// use count, row-level and summary priority searches, result register.
// -----------------------------------------------------------------------------
module ssa_dp #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssa_pkg::t_req i_req,
    input  ssa_pkg::t_cmd i_cmd,
    output ssa_pkg::t_sts o_sts,
    output ssa_pkg::t_rsp o_rsp
);

    import ssa_pkg::*;

    localparam int ROWS   = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RAM_D  = (ROWS > 1) ? ROWS : 2;
    localparam int PW     = ROW_W + WORD_LW;
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int XW     = ((PW > 10) ? PW : 10) + 1;
    localparam int LAST_N = SLOT_COUNT - (ROWS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((64'(1) << LAST_N) - 64'(1));
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    logic              r_op;
    logic [PW-1:0]     r_cur;
    logic [PW-1:0]     r_ptr;
    logic              r_ptr_vld;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [ROWS-1:0]   r_full;
    logic [ROW_W-1:0]  r_tgt;
    logic [ROW_W-1:0]  r_clr;
    t_rsp              r_rsp;

    logic [ROW_W-1:0]   cur_row;
    logic [WORD_LW-1:0] cur_bit;
    logic [WORD_W-1:0]  ram_rd;
    logic [WORD_W-1:0]  row_mask;
    logic [WORD_W-1:0]  tgt_mask;
    logic [WORD_W-1:0]  bit_oh;
    logic [WORD_W-1:0]  set_word;
    logic [WORD_W-1:0]  clr_word;
    logic [WORD_W-1:0]  cand;
    logic [WORD_W-1:0]  cand_low;
    logic [WORD_LW-1:0] cand_idx;
    logic [WORD_W-1:0]  free_w;
    logic [WORD_W-1:0]  free_low;
    logic [WORD_LW-1:0] pick_bit;
    logic [ROWS-1:0]    nf;
    logic [ROWS-1:0]    nf_hi;
    logic [ROWS-1:0]    nf_sel;
    logic [ROWS-1:0]    nf_low;
    logic [ROW_W-1:0]   found_row;
    logic               row_is_full;

    logic               ram_we;
    logic [ROW_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]   ram_raddr;

    assign cur_row  = r_cur[PW-1:WORD_LW];
    assign cur_bit  = r_cur[WORD_LW-1:0];
    assign row_mask = (cur_row == LAST_ROW) ? LAST_MASK : {WORD_W{1'b1}};
    assign tgt_mask = (r_tgt == LAST_ROW) ? LAST_MASK : {WORD_W{1'b1}};
    assign bit_oh   = WORD_W'(1) << cur_bit;
    assign set_word = ram_rd | bit_oh;
    assign clr_word = ram_rd & ~bit_oh;

    // free slots above the granted one, in its own row
    assign cand        = ~set_word & row_mask & (({WORD_W{1'b1}} << cur_bit) << 1);
    assign cand_low    = cand & (~cand + WORD_W'(1));
    assign row_is_full = &(set_word | ~row_mask);

    assign free_w   = ~ram_rd & tgt_mask;
    assign free_low = free_w & (~free_w + WORD_W'(1));

    // summary search: rows above the current one first, then wrap from zero
    assign nf     = ~r_full;
    assign nf_hi  = nf & (({ROWS{1'b1}} << cur_row) << 1);
    assign nf_sel = (|nf_hi) ? nf_hi : nf;
    assign nf_low = nf_sel & (~nf_sel + ROWS'(1));

    always_comb begin
        cand_idx = '0;
        pick_bit = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (cand_low[b]) cand_idx = cand_idx | WORD_LW'(b);
            if (free_low[b]) pick_bit = pick_bit | WORD_LW'(b);
        end
    end

    always_comb begin
        found_row = '0;
        for (int r = 0; r < ROWS; r++) begin
            if (nf_low[r]) found_row = found_row | ROW_W'(r);
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.alloc_mod) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.free_mod && (r_cnt != '0)) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    assign ram_we    = i_cmd.clr_step | i_cmd.alloc_mod | i_cmd.free_mod;
    assign ram_waddr = i_cmd.clr_step ? r_clr : cur_row;
    assign ram_wdata = i_cmd.clr_step  ? '0 :
                       i_cmd.alloc_mod ? set_word : clr_word;
    assign ram_raddr = i_cmd.rd_tgt ? r_tgt : cur_row;

    ssa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_D)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_ptr_vld <= 1'b1;
            r_cnt     <= '0;
            r_full    <= '0;
            r_clr     <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + ROW_W'(1);
            end
            if (i_cmd.alloc_mod) begin
                r_full[cur_row] <= row_is_full;
                if (|cand) begin
                    r_ptr <= {cur_row, cand_idx};
                end
            end
            if (i_cmd.free_mod) begin
                r_full[cur_row] <= 1'b0;
                if (!r_ptr_vld) begin
                    r_ptr     <= r_cur;
                    r_ptr_vld <= 1'b1;
                end
            end
            if (i_cmd.invalidate) begin
                r_ptr_vld <= 1'b0;
            end
            if (i_cmd.pick) begin
                r_ptr <= {r_tgt, pick_bit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_req.operation;
            r_cur <= (i_req.operation == OP_ALLOC) ? r_ptr : PW'(i_req.slot_index);
        end
        if (i_cmd.sum_load) begin
            r_tgt <= found_row;
        end
        if (i_cmd.rsp_load) begin
            r_rsp.status       <= i_cmd.rsp_status;
            r_rsp.granted_slot <= ((i_cmd.rsp_status == ST_DONE) && (r_op == OP_ALLOC))
                                  ? 10'(r_cur) : 10'd0;
            r_rsp.slots_in_use <= 11'(n_cnt);
        end
    end

    assign o_sts.clr_last  = (r_clr == LAST_ROW);
    assign o_sts.pool_full = (r_cnt >= CW'(SLOT_COUNT)) || !r_ptr_vld;
    assign o_sts.idx_ok    = XW'(i_req.slot_index) < XW'(SLOT_COUNT);
    assign o_sts.op_free   = (r_op == OP_FREE);
    assign o_sts.bit_set   = ram_rd[cur_bit];
    assign o_sts.inrow_hit = |cand;
    assign o_sts.row_found = |nf;
    assign o_rsp           = r_rsp;

endmodule

// ----- rtl/ssa_ctrl.sv -----
// -----------------------------------------------------------------------------
// ssa_ctrl
// Allocator controller: bitmap clearing after reset, request sequencing,
// row read-modify-write, summary search and pointer pick, done strobe.
// -----------------------------------------------------------------------------
module ssa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_op,
    input  ssa_pkg::t_sts i_sts,
    output ssa_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    import ssa_pkg::*;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_MOD,
        S_SUM,
        S_SRD,
        S_PICK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == OP_ALLOC && i_sts.pool_full) begin
                        o_cmd.rsp_load   = 1'b1;
                        o_cmd.rsp_status = ST_FULL;
                        n_done           = 1'b1;
                    end else if (i_op == OP_FREE && !i_sts.idx_ok) begin
                        o_cmd.rsp_load   = 1'b1;
                        o_cmd.rsp_status = ST_IGNORED;
                        n_done           = 1'b1;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (i_sts.op_free) begin
                    o_cmd.rsp_load = 1'b1;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                    if (i_sts.bit_set) begin
                        o_cmd.free_mod   = 1'b1;
                        o_cmd.rsp_status = ST_DONE;
                    end else begin
                        o_cmd.rsp_status = ST_IGNORED;
                    end
                end else begin
                    o_cmd.alloc_mod  = 1'b1;
                    o_cmd.rsp_load   = 1'b1;
                    o_cmd.rsp_status = ST_DONE;
                    if (i_sts.inrow_hit) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (i_sts.row_found) begin
                    o_cmd.sum_load = 1'b1;
                    n_state        = S_SRD;
                end else begin
                    // pool now full: drop the pointer
                    o_cmd.invalidate = 1'b1;
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SRD: begin
                o_cmd.rd_tgt = 1'b1;
                n_state      = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ----- rtl/session_slot_allocator.sv -----
// -----------------------------------------------------------------------------
// session_slot_allocator
// Round-robin slot allocator over a bitmap of SLOT_COUNT slots held in RAM
// rows of 32, with per-row full flags for the wrap-around free-slot search.
// -----------------------------------------------------------------------------
// Sequence: o_done is registered. A full pool or out-of-range free is answered from idle;
//   a free, or an allocate whose next free slot lies in its own row, passes the row read
//   and modify states; the row search ends in the summary state when it leaves the pool
//   full, else moves the pointer to another row through the target read and pick states.
// A new request is taken only while busy is low. Reset: synchronous; busy stays high
//   afterwards while the bitmap rows are cleared. Results cannot be stalled.
module session_slot_allocator #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ssa_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output ssa_pkg::t_rsp o_rsp
);

    import ssa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ssa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_req.operation),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ssa_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- rtl/ssa_checker.sv -----
// -----------------------------------------------------------------------------
// ssa_checker
// Port-level checks on the session slot allocator, bound to the top level.
// -----------------------------------------------------------------------------
module ssa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input ssa_pkg::t_rsp o_rsp
);

    import ssa_pkg::*;

    // bitmap clearing holds the block off after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("busy low straight after reset");

    // busy only rises on an accepted request
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) && $past(i_rst_n) |-> $past(start))
        else $error("busy rose without a request");

    // a result follows a request or work in progress
    a_done_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) || $past(start))
        else $error("result without a request");

    // only a successful allocate names a slot
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status != ST_DONE) |-> (o_rsp.granted_slot == 10'd0))
        else $error("slot granted on a failed request");

endmodule

bind session_slot_allocator ssa_checker u_ssa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// ----- tb/sv/session_slot_allocator_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// session_slot_allocator_tb
// Self-checking bench for the slot allocator. A short table of directed
// requests runs first, followed by random allocate/free traffic in phases that
// fill the pool to full, churn around the full mark and drain it again, with
// varying sender gaps. An occupancy model predicts results the table leaves untyped.
// -----------------------------------------------------------------------------
module session_slot_allocator_tb;
    import ssa_pkg::*;

    localparam int SLOTS        = 1024;
    localparam int TAIL_CYCLES  = 12;

    typedef struct packed {
        t_req req;
        bit   typed;
        t_rsp want;
    } dir_row_t;

    typedef struct {
        int items;
        int alloc_pct;
        int idle_pct;
    } phase_t;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // typed expectation travelling alongside a directed request
    bit   drv_typed;
    t_rsp drv_want;

    // occupancy model
    bit          slot_used [SLOTS];
    logic [9:0]  ptr_slot;
    bit          ptr_ok;
    int unsigned used_cnt;

    t_rsp     awaited_rsp [$];
    dir_row_t dir_rows [$];
    phase_t   phases [4];

    int errors;
    int accepted;
    int n_grant;
    int n_full;
    int n_ignored;
    int peak_used;

    session_slot_allocator #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_rsp slot_predict(input t_req r);
        t_rsp        res;
        int unsigned pos;
        res = '0;
        if (r.operation == OP_ALLOC) begin
            if (used_cnt >= SLOTS || !ptr_ok) begin
                res.status = ST_FULL;
            end else begin
                res.status       = ST_DONE;
                res.granted_slot = ptr_slot;
                slot_used[ptr_slot] = 1'b1;
                used_cnt++;
                // wrap-around search above the granted slot; drop the pointer if none
                ptr_ok = 1'b0;
                pos = 32'(ptr_slot);
                for (int i = 1; i < SLOTS; i++) begin
                    pos = (pos + 1) % SLOTS;
                    if (!slot_used[pos]) begin
                        ptr_slot = pos[9:0];
                        ptr_ok   = 1'b1;
                        break;
                    end
                end
            end
        end else begin
            if (r.slot_index >= SLOTS || !slot_used[r.slot_index]) begin
                res.status = ST_IGNORED;
            end else begin
                res.status = ST_DONE;
                slot_used[r.slot_index] = 1'b0;
                if (used_cnt > 0)
                    used_cnt--;
                if (!ptr_ok) begin
                    ptr_slot = r.slot_index;
                    ptr_ok   = 1'b1;
                end
            end
        end
        res.slots_in_use = used_cnt[10:0];
        return res;
    endfunction

    // first used slot at or above 'from', wrapping
    function automatic logic [9:0] pick_used(input logic [9:0] from);
        int unsigned pos;
        for (int i = 0; i < SLOTS; i++) begin
            pos = (from + i) % SLOTS;
            if (slot_used[pos])
                return pos[9:0];
        end
        return from;
    endfunction

    function automatic int draw_gap(input int pct);
        int g;
        g = 0;
        while (g < 24 && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    task automatic add_dir(input logic op, input logic [9:0] idx, input bit typed,
                           input logic [1:0] st, input logic [9:0] slot,
                           input logic [10:0] cnt);
        dir_row_t row;
        row.req.operation     = op;
        row.req.slot_index    = idx;
        row.typed             = typed;
        row.want.status       = st;
        row.want.granted_slot = slot;
        row.want.slots_in_use = cnt;
        dir_rows.push_back(row);
    endtask

    // call at a falling edge; hold the request until it is taken
    task automatic present(input t_req r, input bit typed, input t_rsp want);
        start     <= 1'b1;
        i_req     <= r;
        drv_typed <= typed;
        drv_want  <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                if (awaited_rsp.size() == 0) begin
                    $display("%0t: result with none outstanding: status %0d slot %0d count %0d",
                             $time, o_rsp.status, o_rsp.granted_slot, o_rsp.slots_in_use);
                    errors++;
                end else begin
                    want = awaited_rsp.pop_front();
                    if (o_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_rsp.status);
                        errors++;
                    end
                    if (o_rsp.granted_slot !== want.granted_slot) begin
                        $display("%0t: granted_slot expected %0d, got %0d",
                                 $time, want.granted_slot, o_rsp.granted_slot);
                        errors++;
                    end
                    if (o_rsp.slots_in_use !== want.slots_in_use) begin
                        $display("%0t: slots_in_use expected %0d, got %0d",
                                 $time, want.slots_in_use, o_rsp.slots_in_use);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                // advance the model even when the row carries its own expectation
                want = slot_predict(i_req);
                if (drv_typed)
                    want = drv_want;
                awaited_rsp.push_back(want);
                accepted++;
                case (want.status)
                    ST_DONE:    if (i_req.operation == OP_ALLOC) n_grant++;
                    ST_FULL:    n_full++;
                    ST_IGNORED: n_ignored++;
                    default: ;
                endcase
                if (used_cnt > peak_used)
                    peak_used = used_cnt;
            end
        end
    end

    initial begin : stimulus
        t_req r;
        int   gap;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_req     = '0;
        drv_typed = 1'b0;
        drv_want  = '0;
        errors    = 0;
        accepted  = 0;
        n_grant   = 0;
        n_full    = 0;
        n_ignored = 0;
        peak_used = 0;
        foreach (slot_used[k])
            slot_used[k] = 1'b0;
        ptr_slot = '0;
        ptr_ok   = 1'b1;
        used_cnt = 0;

        // idle frees from reset, first grants, double free, free at zero count
        add_dir(OP_FREE,  10'd0,     1, ST_IGNORED, 10'd0, 11'd0);
        add_dir(OP_FREE,  10'd1023,  1, ST_IGNORED, 10'd0, 11'd0);
        add_dir(OP_ALLOC, 10'd0,     1, ST_DONE,    10'd0, 11'd1);
        add_dir(OP_ALLOC, 10'd1023,  1, ST_DONE,    10'd1, 11'd2);
        add_dir(OP_ALLOC, 10'h155,   1, ST_DONE,    10'd2, 11'd3);
        add_dir(OP_FREE,  10'd1,     1, ST_DONE,    10'd0, 11'd2);
        add_dir(OP_FREE,  10'd1,     1, ST_IGNORED, 10'd0, 11'd2);
        add_dir(OP_ALLOC, 10'h2AA,   0, ST_DONE,    10'd0, 11'd0);
        add_dir(OP_FREE,  10'd3,     0, ST_DONE,    10'd0, 11'd0);
        add_dir(OP_FREE,  10'd2,     0, ST_DONE,    10'd0, 11'd0);
        add_dir(OP_FREE,  10'd0,     0, ST_DONE,    10'd0, 11'd0);
        add_dir(OP_FREE,  10'd0,     1, ST_IGNORED, 10'd0, 11'd0);
        add_dir(OP_ALLOC, 10'h3FF,   0, ST_DONE,    10'd0, 11'd0);
        add_dir(OP_FREE,  10'h3FF,   0, ST_DONE,    10'd0, 11'd0);
        add_dir(OP_FREE,  10'h200,   0, ST_DONE,    10'd0, 11'd0);
        add_dir(OP_FREE,  10'd4,     0, ST_DONE,    10'd0, 11'd0);

        // pool full and the failed search only show up once the fill phase tops out
        phases[0] = '{items: 300,  alloc_pct: 60, idle_pct: 0};
        phases[1] = '{items: 1100, alloc_pct: 95, idle_pct: 70};
        phases[2] = '{items: 250,  alloc_pct: 50, idle_pct: 21};
        phases[3] = '{items: 280,  alloc_pct: 20, idle_pct: 0};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            @(negedge i_clk);
            present(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        end

        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < phases[p].items; n++) begin
                gap = draw_gap(phases[p].idle_pct);
                if (gap > 0) begin
                    @(negedge i_clk);
                    start <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                @(negedge i_clk);
                r.operation  = ($urandom_range(99) < phases[p].alloc_pct) ? OP_ALLOC : OP_FREE;
                r.slot_index = 10'($urandom_range(SLOTS - 1));
                // aim most frees at a slot in use; the rest stay random
                if (r.operation == OP_FREE && used_cnt != 0 && $urandom_range(99) < 80)
                    r.slot_index = pick_used(r.slot_index);
                present(r, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        start     <= 1'b0;
        drv_typed <= 1'b0;

        while (awaited_rsp.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (awaited_rsp.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_rsp.size());
            errors++;
        end
        $display("Ran %0d requests: %0d grants, %0d full-pool answers, %0d ignored frees.",
                 accepted, n_grant, n_full, n_ignored);
        $display("Peak occupancy %0d of %0d slots; %0d mismatches.",
                 peak_used, SLOTS, errors);
        if (errors == 0) begin
            $display("[session_slot_allocator] OK");
        end else begin
            $display("[session_slot_allocator] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("%0t: run did not complete", $time);
        $display("[session_slot_allocator] ERROR");
        $finish;
    end

endmodule
